// File: hw/rtl/rhm_pkg.sv
package rhm_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key;
        logic [31:0] key_hash;
        logic [63:0] value_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        was_new;
        logic [63:0] value_out;
    } rsp_t;

    typedef struct packed {
        logic              used;
        logic [SLOT_W-1:0] probe_len;
        logic [63:0]       key;
        logic [63:0]       value;
    } slot_t;

endpackage

// File: hw/rtl/rhm_ram.sv
module rhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/robin_hood_hash_map.sv
// Robin Hood hash map with backward-shift delete over a 1024-slot table.
// Requests arrive on req (valid/stall) and carry a mode, a 64-bit key, its
// 32-bit hash and a value; each request gives exactly one beat on rsp.
// The home slot is the low bits of key_hash. A request is accepted only
// while the sequencer is idle; one request is in flight at a time.
// Every probe, swap or shift step passes through a read state and a check
// state, because the slot memory has one read port with a registered read.
// A lookup or update that hits at its home slot goes through S_LOC_RD,
// S_LOC_CHK and S_FIN before rsp_valid rises, then returns to S_IDLE for
// the next request. An insert or delete adds a read and a check state for
// each slot visited on top of its search.
// A finished result waits in an output register; the next request is taken
// while it waits, and a second result holds the sequencer until rsp_stall
// drops.
// After reset the block sweeps the table, one slot a cycle, to clear the
// used bits: req_stall stays high until all 1024 slots are written.
module robin_hood_hash_map (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  rhm_pkg::req_t req,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output rhm_pkg::rsp_t rsp
);
    import rhm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOC_RD, S_LOC_CHK, S_INS_RD, S_INS_CHK,
        S_DEL_RD, S_DEL_CHK, S_FIN
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [SLOT_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic [CNT_W-1:0]  cd_reg, cd_next;
    logic [63:0]       ck_reg, ck_next;
    logic [63:0]       cv_reg, cv_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_t             wr_data;
    logic [SLOT_W-1:0] rd_addr;
    slot_t             rd_q;
    logic [$bits(slot_t)-1:0] rd_raw;
    logic [SLOT_W-1:0] home;
    logic [CNT_W-1:0]  plen;
    logic              miss;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
        next_slot = (p == SLOT_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    rhm_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_slots (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_raw)
    );

    assign rd_q      = slot_t'(rd_raw);
    assign home      = SLOT_W'(req.key_hash % SLOTS);
    assign plen      = CNT_W'(rd_q.probe_len);
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_addr   = (state_reg == S_DEL_RD) ? next_slot(p_reg) : p_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        p_next         = p_reg;
        d_next         = d_reg;
        cd_next        = cd_reg;
        ck_next        = ck_reg;
        cv_next        = cv_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = p_reg;
        wr_data        = rd_q;
        miss           = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_reg;
                wr_data      = '0;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    p_next   = home;
                    d_next   = '0;
                    res_next = '{status: ST_MISS, was_new: 1'b0, value_out: 64'd0};
                    if (req.mode == MODE_INSERT || req.mode == MODE_LOOKUP ||
                        req.mode == MODE_DELETE)
                    begin
                        state_next = S_LOC_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_LOC_RD:
            begin
                state_next = S_LOC_CHK;
            end
            S_LOC_CHK:
            begin
                if (!rd_q.used || d_reg > plen)
                begin
                    miss = 1'b1;
                end
                else if (rd_q.key == req_reg.key)
                begin
                    res_next.status = ST_DONE;
                    state_next      = S_FIN;
                    unique case (req_reg.mode)
                        MODE_INSERT:
                        begin
                            wr_en         = 1'b1;
                            wr_data.value = req_reg.value_in;
                        end
                        MODE_LOOKUP:
                        begin
                            res_next.value_out = rd_q.value;
                        end
                        default:
                        begin
                            d_next     = '0;
                            state_next = S_DEL_RD;
                        end
                    endcase
                end
                else
                begin
                    p_next     = next_slot(p_reg);
                    d_next     = d_reg + 1'b1;
                    state_next = S_LOC_RD;
                    if (d_reg == CNT_W'(SLOTS - 1))
                    begin
                        miss = 1'b1;
                    end
                end

                if (miss)
                begin
                    state_next = S_FIN;
                    if (req_reg.mode == MODE_INSERT)
                    begin
                        if (count_reg == CNT_W'(SLOTS))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            // Start over at home carrying the new entry.
                            p_next     = SLOT_W'(req_reg.key_hash % SLOTS);
                            d_next     = '0;
                            cd_next    = '0;
                            ck_next    = req_reg.key;
                            cv_next    = req_reg.value_in;
                            state_next = S_INS_RD;
                        end
                    end
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                wr_data = '{used: 1'b1, probe_len: cd_reg[SLOT_W-1:0],
                            key: ck_reg, value: cv_reg};
                if (!rd_q.used)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    res_next   = '{status: ST_DONE, was_new: 1'b1, value_out: 64'd0};
                    state_next = S_FIN;
                end
                else
                begin
                    // A resident richer than the carried entry gives up its slot.
                    if (cd_reg > plen)
                    begin
                        wr_en   = 1'b1;
                        ck_next = rd_q.key;
                        cv_next = rd_q.value;
                        cd_next = plen + 1'b1;
                    end
                    else
                    begin
                        cd_next = cd_reg + 1'b1;
                    end
                    p_next     = next_slot(p_reg);
                    d_next     = d_reg + 1'b1;
                    state_next = S_INS_RD;
                    if (d_reg == CNT_W'(SLOTS - 1))
                    begin
                        count_next = count_reg + 1'b1;
                        res_next   = '{status: ST_DONE, was_new: 1'b1, value_out: 64'd0};
                        state_next = S_FIN;
                    end
                end
            end
            S_DEL_RD:
            begin
                if (d_reg + 1'b1 >= CNT_W'(SLOTS))
                begin
                    wr_en        = 1'b1;
                    wr_data      = '0;
                    count_next   = count_reg - 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_DEL_CHK;
                end
            end
            S_DEL_CHK:
            begin
                if (!rd_q.used || rd_q.probe_len == '0)
                begin
                    wr_en      = 1'b1;
                    wr_data    = '0;
                    count_next = count_reg - 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    // Pull the displaced entry back into the hole.
                    wr_en             = 1'b1;
                    wr_data.probe_len = rd_q.probe_len - 1'b1;
                    p_next            = next_slot(p_reg);
                    d_next            = d_reg + 1'b1;
                    state_next        = S_DEL_RD;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            req_reg       <= '0;
            p_reg         <= '0;
            d_reg         <= '0;
            cd_reg        <= '0;
            ck_reg        <= '0;
            cv_reg        <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            p_reg         <= p_next;
            d_reg         <= d_next;
            cd_reg        <= cd_next;
            ck_reg        <= ck_next;
            cv_reg        <= cv_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("entry count exceeds table size");

    a_new_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.was_new |-> rsp_reg.status == ST_DONE)
        else $error("new insert reported with failing status");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !wr_en)
        else $error("slot memory written while idle");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> count_reg == $past(count_reg))
        else $error("entry count changed on accept");

endmodule
